/* src/fbm_pkg.sv */
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared field widths, opcodes and status codes of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fbm_pkg;

    localparam int OPCODE_W    = 1;
    localparam int INDEX_W     = 12;
    localparam int FRAME_NUM_W = 12;
    localparam int STATUS_W    = 1;
    localparam int COUNT_W     = 13;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 1'b0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 1'b1;

endpackage

/* src/fbm_if.sv */
// ----------------------------------------------------------------------------
// fbm_if
// Valid/ready channels of the frame bitmap allocator: request, response and
// frame count write.
// ----------------------------------------------------------------------------
interface fbm_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbm_pkg::OPCODE_W-1:0]  opcode;
    logic [fbm_pkg::INDEX_W-1:0]   frame_index;

    modport source (output valid, output opcode, output frame_index, input ready);
    modport sink   (input valid, input opcode, input frame_index, output ready);
endinterface

interface fbm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [fbm_pkg::FRAME_NUM_W-1:0] frame_number;
    logic [fbm_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output frame_number, output status, input ready);
    modport sink   (input valid, input frame_number, input status, output ready);
endinterface

interface fbm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fbm_pkg::COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/fbm_ram.sv */
// ----------------------------------------------------------------------------
// fbm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/frame_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// Page frame allocator over a bitmap of used frames held in one RAM.
//
//   channel  dir  beat contents
//   -------  ---  -------------------------------
//   req      in   opcode, frame_index
//   rsp      out  frame_number, status
//   cfg      in   frame_count (13 bits, always ready)
//
// A request scans bitmap words from word 0, one RAM read per cycle, and stops
// at the first word with a free frame (allocate) or at the word holding the
// frame (free), or after the last word below the limit (a miss).
// After reset a clearing pass writes MAP_WORDS zero words; req.ready stays low.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fbm_req_if.sink    req,
    fbm_rsp_if.source  rsp,
    fbm_cfg_if.sink    cfg
);

    localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int CMP_W     = (BASE_W > fbm_pkg::COUNT_W) ? BASE_W : fbm_pkg::COUNT_W;

    localparam logic [CMP_W-1:0]   MAX_LIMIT = CMP_W'(MAX_FRAMES);
    localparam logic [CMP_W-1:0]   WORD_STEP = CMP_W'(WORD_BITS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control
    logic [1:0]                   state_reg, state_next;
    logic [WADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [fbm_pkg::COUNT_W-1:0]  frame_count_reg, frame_count_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    logic [fbm_pkg::OPCODE_W-1:0]    op_reg, op_next;
    logic [fbm_pkg::INDEX_W-1:0]     idx_reg, idx_next;
    logic [CMP_W-1:0]                limit_reg, limit_next;
    logic [WADDR_W-1:0]              rd_addr_reg, rd_addr_next;
    logic [CMP_W-1:0]                rd_base_reg, rd_base_next;
    logic [WADDR_W-1:0]              chk_addr_reg, chk_addr_next;
    logic [CMP_W-1:0]                chk_base_reg, chk_base_next;
    logic [fbm_pkg::FRAME_NUM_W-1:0] res_frame_reg, res_frame_next;
    logic [fbm_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [fbm_pkg::FRAME_NUM_W-1:0] out_frame_reg, out_frame_next;
    logic [fbm_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    // RAM
    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    // word check
    logic [CMP_W-1:0]     eff_limit;
    logic [CMP_W-1:0]     rem;
    logic [CMP_W-1:0]     idx_off;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_bit;
    logic [BIT_W-1:0]     alloc_bit;
    logic [BIT_W-1:0]     free_bit;
    logic                 alloc_hit;
    logic                 free_hit;
    logic                 hit;
    logic                 more;
    logic                 issue;
    logic                 finish;
    logic                 accept;
    logic                 out_free;

    fbm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign eff_limit = (CMP_W'(frame_count_reg) > MAX_LIMIT) ? MAX_LIMIT
                                                              : CMP_W'(frame_count_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid        = out_valid_reg;
    assign rsp.frame_number = out_frame_reg;
    assign rsp.status       = out_status_reg;
    assign out_free         = !out_valid_reg || rsp.ready;

    // Free frames of the checked word that lie below the limit.
    assign rem = limit_reg - chk_base_reg;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            free_bits[b] = !ram_rdata[b] && (CMP_W'(b) < rem);
        end
    end

    // isolate the lowest free frame
    assign low_bit = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        alloc_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            alloc_bit = alloc_bit | (low_bit[b] ? BIT_W'(b) : '0);
        end
    end

    assign alloc_hit = |free_bits;
    assign idx_off   = CMP_W'(idx_reg) - chk_base_reg;
    assign free_hit  = (idx_off < WORD_STEP) && (CMP_W'(idx_reg) < limit_reg);
    assign free_bit  = idx_off[BIT_W-1:0];

    assign hit    = chk_valid_reg && ((op_reg == fbm_pkg::OP_ALLOC) ? alloc_hit : free_hit);
    assign more   = rd_base_reg < limit_reg;
    assign issue  = (state_reg == S_SCAN) && more && !hit;
    assign finish = (state_reg == S_SCAN) && (hit || (!chk_valid_reg && !more));
    assign ram_re = issue;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_addr_reg;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_bit);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (finish && hit)
        begin
            ram_we = 1'b1;
            if (op_reg == fbm_pkg::OP_ALLOC)
            begin
                ram_wdata = ram_rdata | low_bit;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        frame_count_next = frame_count_reg;
        chk_valid_next   = chk_valid_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        limit_next       = limit_reg;
        rd_addr_next     = rd_addr_reg;
        rd_base_next     = rd_base_reg;
        chk_addr_next    = chk_addr_reg;
        chk_base_next    = chk_base_reg;
        res_frame_next   = res_frame_reg;
        res_status_next  = res_status_reg;
        out_frame_next   = out_frame_reg;
        out_status_next  = out_status_reg;

        if (cfg.valid)
        begin
            frame_count_next = cfg.data;
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + WADDR_W'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.opcode;
                    idx_next       = req.frame_index;
                    limit_next     = eff_limit;
                    rd_addr_next   = '0;
                    rd_base_next   = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // advance the read pointer; the checked word follows it in the next cycle
                chk_valid_next = issue;
                chk_addr_next  = rd_addr_reg;
                chk_base_next  = rd_base_reg;
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + WADDR_W'(1);
                    rd_base_next = rd_base_reg + WORD_STEP;
                end
                if (finish)
                begin
                    chk_valid_next  = 1'b0;
                    res_frame_next  = '0;
                    res_status_next = fbm_pkg::ST_DONE;
                    if (op_reg == fbm_pkg::OP_ALLOC)
                    begin
                        if (hit)
                        begin
                            res_frame_next = fbm_pkg::FRAME_NUM_W'(chk_base_reg
                                                                   + CMP_W'(alloc_bit));
                        end
                        else
                        begin
                            res_status_next = fbm_pkg::ST_NO_FREE;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_frame_next  = res_frame_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            frame_count_reg <= fbm_pkg::COUNT_RESET;
            chk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            frame_count_reg <= frame_count_next;
            chk_valid_reg   <= chk_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        limit_reg      <= limit_next;
        rd_addr_reg    <= rd_addr_next;
        rd_base_reg    <= rd_base_next;
        chk_addr_reg   <= chk_addr_next;
        chk_base_reg   <= chk_base_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
    end

endmodule

/* src/fbm_checker.sv */
// ----------------------------------------------------------------------------
// fbm_checker
// Port-level checks of the frame bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [fbm_pkg::FRAME_NUM_W-1:0] rsp_frame_number,
    input logic [fbm_pkg::STATUS_W-1:0]    rsp_status
);

    logic [1:0] pending_reg, pending_next;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    // requests taken whose response beat has not gone out yet
    always_comb
    begin
        pending_next = pending_reg;
        if (req_beat && !rsp_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_beat && !req_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("rsp valid dropped before ready");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == fbm_pkg::ST_NO_FREE)) |-> (rsp_frame_number == '0))
        else $error("failed allocate carries a nonzero frame number");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_beat |=> !req_ready)
        else $error("request taken while a scan is running");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("response without a pending request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests in flight");

endmodule

bind frame_bitmap_allocator fbm_checker u_fbm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_frame_number (rsp.frame_number),
    .rsp_status       (rsp.status)
);

/* verif/tb_frame_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator
// Drives allocate and free requests into the frame bitmap allocator under
// several frame counts and handshake idling patterns, predicts every result
// from a local copy of the used-frame map, and compares responses in order.
// ----------------------------------------------------------------------------
module tb_frame_bitmap_allocator;

    import fbm_pkg::*;

    localparam int NFRAMES   = 4096;
    localparam int WORD_SZ   = 32;
    localparam int LIMIT     = 1000000;
    localparam int TAIL_WAIT = 150;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  frame_index;
    } frame_op_t;

    typedef struct packed {
        logic [FRAME_NUM_W-1:0] frame_number;
        logic [STATUS_W-1:0]    status;
    } frame_grant_t;

    logic clk;
    logic rst_n;

    fbm_req_if req_ch ();
    fbm_rsp_if rsp_ch ();
    fbm_cfg_if cfg_ch ();

    frame_bitmap_allocator #(
        .MAX_FRAMES (NFRAMES),
        .WORD_BITS  (WORD_SZ)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    frame_op_t          op_q[$];
    frame_grant_t       grant_q[$];
    frame_op_t          cur_op;
    bit [NFRAMES-1:0]   frames_used;
    bit [NFRAMES-1:0]   plan_used;
    logic [COUNT_W-1:0] frame_count_q;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    int unsigned        hold_left;
    int unsigned        cycles;
    int unsigned        mismatches;

    function automatic int unsigned usable_frames(input logic [COUNT_W-1:0] count);
        return (count > NFRAMES) ? NFRAMES : int'(count);
    endfunction

    // Apply one request to a used-frame map and return the response it yields.
    function automatic frame_grant_t run_frame_op(inout bit [NFRAMES-1:0] map,
                                                  input int unsigned lim,
                                                  input frame_op_t op);
        frame_grant_t res;
        bit           found;
        res.frame_number = '0;
        res.status       = ST_DONE;
        found            = 1'b0;
        if (op.opcode == OP_ALLOC) begin
            for (int unsigned f = 0; f < lim && !found; f++) begin
                if (!map[f]) begin
                    map[f]           = 1'b1;
                    res.frame_number = f[FRAME_NUM_W-1:0];
                    found            = 1'b1;
                end
            end
            if (!found)
                res.status = ST_NO_FREE;
        end
        else if (op.frame_index < lim) begin
            map[op.frame_index] = 1'b0;
        end
        return res;
    endfunction

    // Pick a frame the plan holds as used, starting at a random spot; if none, any frame.
    function automatic logic [INDEX_W-1:0] pick_used(input int unsigned lim);
        int unsigned start;
        int unsigned f;
        if (lim == 0)
            return INDEX_W'($urandom_range(NFRAMES - 1));
        start = $urandom_range(lim - 1);
        for (int unsigned k = 0; k < lim; k++) begin
            f = (start + k) % lim;
            if (plan_used[f])
                return f[INDEX_W-1:0];
        end
        return INDEX_W'($urandom_range(NFRAMES - 1));
    endfunction

    task automatic push_op(input logic [OPCODE_W-1:0] opc, input logic [INDEX_W-1:0] idx);
        frame_op_t op;
        op.opcode      = opc;
        op.frame_index = idx;
        void'(run_frame_op(plan_used, usable_frames(frame_count_q), op));
        op_q.push_back(op);
    endtask

    task automatic push_random_ops(input int n, input int unsigned alloc_pct);
        int unsigned lim;
        lim = usable_frames(frame_count_q);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < alloc_pct)
                push_op(OP_ALLOC, INDEX_W'($urandom_range(NFRAMES - 1)));
            else if ($urandom_range(9) < 6)
                push_op(OP_FREE, pick_used(lim));
            else
                push_op(OP_FREE, INDEX_W'($urandom_range(NFRAMES - 1)));
        end
    endtask

    // Wait until no request is pending, in flight or awaiting its response.
    task automatic drain();
        do
            @(negedge clk);
        while (op_q.size() != 0 || req_ch.valid || grant_q.size() != 0);
    endtask

    task automatic write_frame_count(input logic [COUNT_W-1:0] value);
        drain();
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid  <= 1'b0;
        frame_count_q = value;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] count, input int unsigned send_pct,
                             input int unsigned recv_pct, input int n,
                             input int unsigned alloc_pct);
        write_frame_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        push_random_ops(n, alloc_pct);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Request driver: predict on each accepted beat, then offer the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                grant_q.push_back(run_frame_op(frames_used, usable_frames(frame_count_q),
                                               cur_op));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_op = op_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.opcode      <= cur_op.opcode;
                    req_ch.frame_index <= cur_op.frame_index;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Response monitor: compare every beat with the oldest predicted grant.
    always @(posedge clk)
    begin
        frame_grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (grant_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_SHOWN)
                    $display("unexpected response: frame_number %0d status %0d",
                             rsp_ch.frame_number, rsp_ch.status);
            end
            else
            begin
                want = grant_q.pop_front();
                if (rsp_ch.frame_number !== want.frame_number || rsp_ch.status !== want.status)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_SHOWN)
                        $display("mismatch: frame_number exp %0d got %0d, status exp %0d got %0d",
                                 want.frame_number, rsp_ch.frame_number,
                                 want.status, rsp_ch.status);
                end
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_ALLOC;
        req_ch.frame_index = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        frames_used        = '0;
        plan_used          = '0;
        frame_count_q      = COUNT_RESET;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_left          = 0;
        cycles             = 0;
        mismatches         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset count: basic allocate and free, double free, ignored index bits.
        push_op(OP_ALLOC, '0);
        push_op(OP_ALLOC, '0);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd1);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'hFFF);
        push_op(OP_FREE, 12'd0);
        push_op(OP_FREE, 12'd0);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'hAAA);
        push_op(OP_FREE, 12'h555);
        push_op(OP_ALLOC, 12'hFFF);

        // Zero frames: every allocate fails, every free is out of range.
        write_frame_count(13'd0);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd0);
        push_op(OP_ALLOC, 12'hFFF);

        // Lowered count with frames above it still marked used.
        write_frame_count(13'd3);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd2);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd3);

        // Count above capacity clamps to the full map.
        write_frame_count(13'd8191);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd3);
        push_op(OP_ALLOC, '0);
        push_op(OP_FREE, 12'd4095);

        run_phase(13'd4096, 0, 0, 120, 70);
        run_phase(13'd8191, 45, 0, 120, 60);
        run_phase(13'd1, 0, 45, 60, 50);
        run_phase(13'd32, 12, 12, 120, 65);
        run_phase(13'd33, 0, 0, 110, 65);
        run_phase(13'd0, 45, 0, 40, 50);
        run_phase(13'd200, 0, 45, 140, 75);
        run_phase(13'd4095, 12, 12, 110, 60);

        // Hold off the response side so the block backs up into the request side.
        write_frame_count(13'd64);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 500;
        push_random_ops(140, 70);

        run_phase(13'd517, 45, 0, 140, 70);
        run_phase(13'd4097, 0, 45, 110, 55);
        run_phase(13'd96, 12, 12, 140, 70);
        run_phase(13'd7, 0, 0, 90, 50);
        run_phase(13'd4096, 12, 12, 80, 50);

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
